### rtl/bgcr_pkg.sv
// ----------------------------------------------------------------------------
// Bitmap glyph column renderer package
// Shared sizes, codes, transaction structures and helper functions.
// ----------------------------------------------------------------------------
package bgcr_pkg;

   localparam int BITMAP_BYTES  = 16384;
   localparam int ADDR_W        = $clog2(BITMAP_BYTES);
   localparam int GLYPH_ENTRIES = 256;
   localparam int GIDX_W        = $clog2(GLYPH_ENTRIES);
   localparam int COLUMN_LIMIT  = 32;
   localparam int MAX_HEIGHT    = 32;
   localparam int MAX_ROWS      = (MAX_HEIGHT + 7) / 8;
   localparam int ROW_W         = $clog2(MAX_ROWS);
   localparam int QUEUE_DEPTH   = 2;
   localparam int QPTR_W        = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W        = $clog2(QUEUE_DEPTH + 1);

   // Request tdata: char_code, byte_address, byte_value, entry_offset,
   // entry_width, start_x, start_y, clip_right, clip_bottom.
   localparam int REQ_DATA_W = 120;
   // Response tdata: column_x, column_top, column_bits, advance, total_width.
   localparam int RSP_DATA_W = 88;

   typedef enum logic [2:0] {
      OP_LOAD_BYTE  = 3'd0,
      OP_LOAD_ENTRY = 3'd1,
      OP_START_LINE = 3'd2,
      OP_DRAW       = 3'd3,
      OP_MEASURE    = 3'd4
   } op_type;

   typedef enum logic [1:0] {
      KIND_COLUMN  = 2'd0,
      KIND_NOTHING = 2'd1,
      KIND_MEASURE = 2'd2,
      KIND_ACK     = 2'd3
   } kind_type;

   typedef enum logic [2:0] {
      CMD_LOAD_BYTE,
      CMD_LOAD_ENTRY,
      CMD_START_LINE,
      CMD_DRAW,
      CMD_MEASURE,
      CMD_SKIP
   } cmd_type;

   typedef enum logic [1:0] {
      CSR_FIRST_CODE   = 2'd0,
      CSR_GLYPH_HEIGHT = 2'd1,
      CSR_FIXED_WIDTH  = 2'd2,
      CSR_PROPORTIONAL = 2'd3
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXEC,
      ST_COLUMN,
      ST_READ,
      ST_GATHER,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic [7:0] first_code;
      logic [5:0] glyph_height;
      logic [5:0] fixed_width;
      logic       proportional;
   } cfg_type;

   typedef struct packed {
      cmd_type            cmd;
      logic [7:0]         char_code;
      logic [7:0]         idx;
      logic [ADDR_W-1:0]  byte_address;
      logic [7:0]         byte_value;
      logic [15:0]        entry_offset;
      logic [5:0]         entry_width;
      logic signed [15:0] start_x;
      logic signed [15:0] start_y;
      logic signed [15:0] clip_right;
      logic signed [15:0] clip_bottom;
      logic [15:0]        fixed_prod;
   } entry_type;

   function automatic logic [5:0] sat_width(input logic [5:0] v);
      return (v > 6'(COLUMN_LIMIT)) ? 6'(COLUMN_LIMIT) : v;
   endfunction

endpackage

### rtl/bgcr_front.sv
// ----------------------------------------------------------------------------
// Front end
// Accepts request transactions and classifies them into commands.
// ----------------------------------------------------------------------------
module bgcr_front (
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [bgcr_pkg::REQ_DATA_W-1:0]    req_tdata,
   input  logic [2:0]                         req_tuser,
   input  bgcr_pkg::cfg_type                  cfg,
   input  logic                               q_full,
   output logic                               q_push,
   output bgcr_pkg::entry_type                q_data
);
   import bgcr_pkg::*;

   logic [7:0] ch;
   logic [7:0] idx;
   logic       idx_ok;
   logic [5:0] wfix;

   assign req_tready = !q_full;
   assign q_push     = req_tvalid && !q_full;

   always_comb begin
      ch     = req_tdata[7:0];
      idx    = ch - cfg.first_code;
      wfix   = sat_width(cfg.fixed_width);
      // Codes above 0x80 or below the first glyph are skipped; proportional
      // fonts also need the index inside the glyph table.
      idx_ok = (ch <= 8'h80) && (ch >= cfg.first_code) &&
               (!cfg.proportional || ({1'b0, idx} < 9'(GLYPH_ENTRIES)));

      q_data.char_code    = ch;
      q_data.idx          = idx;
      q_data.byte_address = req_tdata[8 +: ADDR_W];
      q_data.byte_value   = req_tdata[31:24];
      q_data.entry_offset = req_tdata[47:32];
      q_data.entry_width  = sat_width(req_tdata[53:48]);
      q_data.start_x      = req_tdata[69:54];
      q_data.start_y      = req_tdata[85:70];
      q_data.clip_right   = req_tdata[101:86];
      q_data.clip_bottom  = req_tdata[117:102];
      q_data.fixed_prod   = 16'(idx) * 16'(wfix);

      case (req_tuser)
         OP_LOAD_BYTE:  q_data.cmd = CMD_LOAD_BYTE;
         OP_LOAD_ENTRY: q_data.cmd = CMD_LOAD_ENTRY;
         OP_START_LINE: q_data.cmd = CMD_START_LINE;
         OP_DRAW:       q_data.cmd = idx_ok ? CMD_DRAW : CMD_SKIP;
         OP_MEASURE:    q_data.cmd = (!cfg.proportional || idx_ok) ? CMD_MEASURE : CMD_SKIP;
         default:       q_data.cmd = CMD_SKIP;
      endcase
   end

endmodule

### rtl/bgcr_queue.sv
// ----------------------------------------------------------------------------
// Command queue
// Short first-in first-out buffer between the front and back ends.
// ----------------------------------------------------------------------------
module bgcr_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  bgcr_pkg::entry_type push_data,
   input  logic                pop,
   output logic                full,
   output logic                head_valid,
   output bgcr_pkg::entry_type head
);
   import bgcr_pkg::*;

   entry_type           slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   count_ff, count_in;

   assign full       = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head       = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? QPTR_W'(wr_ptr_ff + 1'b1) : wr_ptr_ff;
      rd_ptr_in = pop  ? QPTR_W'(rd_ptr_ff + 1'b1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = QCNT_W'(count_ff + 1'b1);
      end else if (pop && !push) begin
         count_in = QCNT_W'(count_ff - 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

### rtl/bgcr_back.sv
// ----------------------------------------------------------------------------
// Back end
// Executes commands: owns the bitmap and glyph tables, the line state and
// the response register, and walks glyph columns one byte row at a time.
// ----------------------------------------------------------------------------
module bgcr_back (
   input  logic                            clock,
   input  logic                            reset,
   input  bgcr_pkg::cfg_type               cfg,
   input  logic                            q_valid,
   input  bgcr_pkg::entry_type             q_head,
   output logic                            q_pop,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [bgcr_pkg::RSP_DATA_W-1:0] rsp_tdata,
   output logic [1:0]                      rsp_tuser,
   output logic                            rsp_tlast
);
   import bgcr_pkg::*;

   logic [7:0]  bitmap_mem [BITMAP_BYTES];
   logic [15:0] offset_mem [GLYPH_ENTRIES];
   logic [5:0]  width_mem  [GLYPH_ENTRIES];

   state_type          state_ff, state_in;
   entry_type          cur_ff, cur_in;
   logic signed [15:0] cursor_ff, cursor_in;
   logic signed [15:0] top_ff, top_in;
   logic signed [15:0] right_ff, right_in;
   logic signed [15:0] bottom_ff, bottom_in;
   logic [15:0]        total_ff, total_in;
   logic [5:0]         w_ff, w_in;
   logic [ADDR_W-1:0]  pos_ff, pos_in;
   logic [5:0]         col_ff, col_in;
   logic [ROW_W-1:0]   row_ff, row_in;
   logic [31:0]        bits_ff, bits_in;
   logic [7:0]         bm_rdata_ff;
   logic [15:0]        g_off_ff;
   logic [5:0]         g_w_ff;

   logic               rsp_valid_ff, rsp_valid_in;
   kind_type           rsp_kind_ff, rsp_kind_in;
   logic [15:0]        rsp_x_ff, rsp_x_in;
   logic [15:0]        rsp_top_ff, rsp_top_in;
   logic [31:0]        rsp_bits_ff, rsp_bits_in;
   logic [5:0]         rsp_adv_ff, rsp_adv_in;
   logic [15:0]        rsp_total_ff, rsp_total_in;
   logic               rsp_last_ff, rsp_last_in;

   logic               out_free;
   logic               bm_we, bm_re, tbl_we;
   logic [ADDR_W-1:0]  bm_raddr;
   logic [6:0]         row_off;
   logic [2:0]         rows;
   logic [5:0]         h_sat;
   logic [5:0]         w_now;
   logic signed [16:0] col_x;
   logic signed [16:0] next_x;
   logic [16:0]        next_total;
   logic signed [16:0] depth;
   logic [31:0]        mask;
   logic               clipped;

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tdata  = {2'b00, rsp_total_ff, rsp_adv_ff, rsp_bits_ff, rsp_top_ff, rsp_x_ff};

   always_comb begin
      h_sat   = (cfg.glyph_height > 6'(MAX_HEIGHT)) ? 6'(MAX_HEIGHT) : cfg.glyph_height;
      rows    = 3'((7'(h_sat) + 7'd7) >> 3);
      w_now   = cfg.proportional ? g_w_ff : sat_width(cfg.fixed_width);
      row_off = 7'(row_ff) * 7'(w_ff);
      bm_raddr = ADDR_W'(pos_ff + ADDR_W'(col_ff) + ADDR_W'(row_off));
      col_x   = $signed({cursor_ff[15], cursor_ff}) + $signed({11'd0, col_ff});
      clipped = (col_x > $signed({right_ff[15], right_ff})) || (col_x > 17'sd32767);
      next_x  = $signed({cursor_ff[15], cursor_ff}) + $signed({11'd0, w_ff});
      next_total = 17'(total_ff) + 17'(w_now);
      depth   = $signed({bottom_ff[15], bottom_ff}) - $signed({top_ff[15], top_ff});
      for (int k = 0; k < 32; k++) begin
         mask[k] = (depth >= $signed(17'(k)));
      end
   end

   always_comb begin
      state_in     = state_ff;
      cur_in       = cur_ff;
      cursor_in    = cursor_ff;
      top_in       = top_ff;
      right_in     = right_ff;
      bottom_in    = bottom_ff;
      total_in     = total_ff;
      w_in         = w_ff;
      pos_in       = pos_ff;
      col_in       = col_ff;
      row_in       = row_ff;
      bits_in      = bits_ff;
      q_pop        = 1'b0;
      bm_we        = 1'b0;
      bm_re        = 1'b0;
      tbl_we       = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_kind_in  = rsp_kind_ff;
      rsp_x_in     = rsp_x_ff;
      rsp_top_in   = rsp_top_ff;
      rsp_bits_in  = rsp_bits_ff;
      rsp_adv_in   = rsp_adv_ff;
      rsp_total_in = rsp_total_ff;
      rsp_last_in  = rsp_last_ff;

      case (state_ff)
         ST_IDLE: begin
            if (q_valid) begin
               q_pop    = 1'b1;
               cur_in   = q_head;
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (cur_ff.cmd == CMD_DRAW && w_now != 6'd0) begin
               w_in     = w_now;
               pos_in   = cfg.proportional ? g_off_ff[ADDR_W-1:0]
                                           : ADDR_W'(cur_ff.fixed_prod * 16'(rows));
               col_in   = '0;
               state_in = ST_COLUMN;
            end else if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_kind_in  = KIND_NOTHING;
               rsp_x_in     = cursor_ff;
               rsp_top_in   = top_ff;
               rsp_bits_in  = '0;
               rsp_adv_in   = '0;
               rsp_total_in = total_ff;
               rsp_last_in  = 1'b1;
               state_in     = ST_IDLE;
               case (cur_ff.cmd)
                  CMD_LOAD_BYTE: begin
                     bm_we       = 1'b1;
                     rsp_kind_in = KIND_ACK;
                  end
                  CMD_LOAD_ENTRY: begin
                     tbl_we      = 1'b1;
                     rsp_kind_in = KIND_ACK;
                  end
                  CMD_START_LINE: begin
                     cursor_in    = cur_ff.start_x;
                     top_in       = cur_ff.start_y;
                     right_in     = cur_ff.clip_right;
                     bottom_in    = cur_ff.clip_bottom;
                     total_in     = '0;
                     rsp_kind_in  = KIND_ACK;
                     rsp_x_in     = cur_ff.start_x;
                     rsp_top_in   = cur_ff.start_y;
                     rsp_total_in = '0;
                  end
                  CMD_MEASURE: begin
                     total_in     = next_total[16] ? 16'hFFFF : next_total[15:0];
                     rsp_kind_in  = KIND_MEASURE;
                     rsp_adv_in   = w_now;
                     rsp_total_in = next_total[16] ? 16'hFFFF : next_total[15:0];
                  end
                  default: begin
                     rsp_kind_in = KIND_NOTHING;
                  end
               endcase
            end
         end
         ST_COLUMN: begin
            bits_in  = '0;
            row_in   = '0;
            state_in = clipped ? ST_EMIT : ST_READ;
         end
         ST_READ: begin
            bm_re    = 1'b1;
            state_in = ST_GATHER;
         end
         ST_GATHER: begin
            bits_in[{row_ff, 3'b000} +: 8] = bm_rdata_ff;
            if (3'(row_ff) == rows - 3'd1) begin
               state_in = ST_EMIT;
            end else begin
               row_in   = ROW_W'(row_ff + 1'b1);
               state_in = ST_READ;
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_kind_in  = KIND_COLUMN;
               rsp_x_in     = (col_x > 17'sd32767) ? 16'h7FFF : col_x[15:0];
               rsp_top_in   = top_ff;
               rsp_bits_in  = bits_ff & mask;
               rsp_adv_in   = w_ff;
               rsp_total_in = total_ff;
               rsp_last_in  = (col_ff == w_ff - 6'd1);
               if (col_ff == w_ff - 6'd1) begin
                  cursor_in = (next_x > 17'sd32767) ? 16'sh7FFF : next_x[15:0];
                  state_in  = ST_IDLE;
               end else begin
                  col_in   = col_ff + 6'd1;
                  state_in = ST_COLUMN;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cursor_ff    <= '0;
         top_ff       <= '0;
         right_ff     <= 16'sh7FFF;
         bottom_ff    <= 16'sh7FFF;
         total_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cursor_ff    <= cursor_in;
         top_ff       <= top_in;
         right_ff     <= right_in;
         bottom_ff    <= bottom_in;
         total_ff     <= total_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff       <= cur_in;
      w_ff         <= w_in;
      pos_ff       <= pos_in;
      col_ff       <= col_in;
      row_ff       <= row_in;
      bits_ff      <= bits_in;
      rsp_kind_ff  <= rsp_kind_in;
      rsp_x_ff     <= rsp_x_in;
      rsp_top_ff   <= rsp_top_in;
      rsp_bits_ff  <= rsp_bits_in;
      rsp_adv_ff   <= rsp_adv_in;
      rsp_total_ff <= rsp_total_in;
      rsp_last_ff  <= rsp_last_in;
   end

   always_ff @(posedge clock) begin
      if (bm_we) begin
         bitmap_mem[cur_ff.byte_address] <= cur_ff.byte_value;
      end
      if (bm_re) begin
         bm_rdata_ff <= bitmap_mem[bm_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (tbl_we) begin
         offset_mem[cur_ff.char_code[GIDX_W-1:0]] <= cur_ff.entry_offset;
         width_mem[cur_ff.char_code[GIDX_W-1:0]]  <= cur_ff.entry_width;
      end
      if (q_pop) begin
         g_off_ff <= offset_mem[q_head.idx[GIDX_W-1:0]];
         g_w_ff   <= width_mem[q_head.idx[GIDX_W-1:0]];
      end
   end

endmodule

### rtl/bitmap_glyph_column_renderer.sv
// ----------------------------------------------------------------------------
// Bitmap glyph column renderer
// Character generator that turns character codes into glyph pixel columns.
// ----------------------------------------------------------------------------
// Each request transaction is one operation: load a bitmap byte, load a glyph
// table entry, start a text line, draw a character or measure it. A front end
// classifies requests into a two-entry queue, so a new transaction is taken
// while the back end is still drawing. The back end handles one command at a
// time. A drawn character walks each column: the column state, a read and a
// gather state for each of (glyph_height + 7) / 8 byte rows, then the emit
// state; a column clipped on the right skips the reads. Other commands are
// answered in the execute state once the response register is free. Rows
// come through the bitmap memory's single read port, whose data is registered
// before it is placed in the column. Every drawn column is one response
// transaction, the last one flagged on rsp_tlast; other operations give one
// response. Configuration registers are written through the csr port and take
// effect at once; they must only be written while no transaction is pending.
// ----------------------------------------------------------------------------
module bitmap_glyph_column_renderer (
   input  logic                            clock,
   input  logic                            reset,
   // char_code, byte_address, byte_value, entry_offset, entry_width,
   // start_x, start_y, clip_right, clip_bottom (from bit 0 up)
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [bgcr_pkg::REQ_DATA_W-1:0] req_tdata,
   input  logic [2:0]                      req_tuser,   // operation
   // column_x, column_top, column_bits, advance, total_width (from bit 0 up)
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [bgcr_pkg::RSP_DATA_W-1:0] rsp_tdata,
   output logic [1:0]                      rsp_tuser,   // kind
   output logic                            rsp_tlast,
   input  logic                            csr_we,
   input  logic [1:0]                      csr_index,
   input  logic [7:0]                      csr_wdata
);
   import bgcr_pkg::*;

   cfg_type   cfg_ff, cfg_in;
   logic      q_push, q_pop, q_full, q_valid;
   entry_type q_data, q_head;

   // Configuration registers, written one at a time.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_FIRST_CODE:   cfg_in.first_code   = csr_wdata;
            CSR_GLYPH_HEIGHT: cfg_in.glyph_height = csr_wdata[5:0];
            CSR_FIXED_WIDTH:  cfg_in.fixed_width  = csr_wdata[5:0];
            CSR_PROPORTIONAL: cfg_in.proportional = csr_wdata[0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.first_code   <= 8'd32;
         cfg_ff.glyph_height <= 6'd16;
         cfg_ff.fixed_width  <= 6'd8;
         cfg_ff.proportional <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // The front end decodes each request transaction into a command.
   bgcr_front u_front (
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .cfg        (cfg_ff),
      .q_full     (q_full),
      .q_push     (q_push),
      .q_data     (q_data)
   );

   // The queue lets the front end keep accepting while a glyph is drawn.
   bgcr_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_data  (q_data),
      .pop        (q_pop),
      .full       (q_full),
      .head_valid (q_valid),
      .head       (q_head)
   );

   // The back end owns all stores and line state, and the response register.
   bgcr_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .q_valid    (q_valid),
      .q_head     (q_head),
      .q_pop      (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

`ifndef NO_ASSERTIONS
   // A command is only taken from the queue when one is there.
   assert property (@(posedge clock) disable iff (reset) q_pop |-> q_valid)
      else $error("queue popped while empty");

   // Nothing is pushed into a full queue.
   assert property (@(posedge clock) disable iff (reset) q_push |-> !q_full)
      else $error("queue pushed while full");

   // Every response that is not a column is the only one of its transaction.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser != KIND_COLUMN) |-> rsp_tlast)
      else $error("single response without last flag");

   // Only columns carry pixels.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser != KIND_COLUMN) |-> (rsp_tdata[63:32] == 32'd0))
      else $error("pixels on a non-column response");

   // No response is pending in the cycle after reset.
   assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("response valid after reset");
`endif

endmodule

### test/testbench.sv
// ----------------------------------------------------------------------------
// Bitmap glyph column renderer testbench
// Drives load, line start, draw and measure transactions into the renderer,
// predicts every response from a behavioural copy of the font state and
// compares the responses field by field, under random idling on both sides.
// ----------------------------------------------------------------------------
module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import bgcr_pkg::*;

   // Operation codes 5 to 7 are not defined and must be answered with a
   // nothing-drawn response.
   localparam logic [2:0] OP_UNUSED = 3'd5;
   // Cycles without any accepted transaction before the run is abandoned.
   localparam int STALL_LIMIT = 20000;
   // Cycles allowed for the block to settle once all responses are in.
   localparam int SETTLE_CYCLES = 20;

   typedef struct packed {
      logic [2:0]         op;
      logic [7:0]         ch;
      logic [15:0]        addr;
      logic [7:0]         bval;
      logic [15:0]        eoff;
      logic [5:0]         ewid;
      logic signed [15:0] sx;
      logic signed [15:0] sy;
      logic signed [15:0] cr;
      logic signed [15:0] cb;
   } glyph_req_type;

   localparam int REQ_BITS = $bits(glyph_req_type);

   typedef struct packed {
      logic [1:0]         kind;
      logic signed [15:0] x;
      logic signed [15:0] top;
      logic [31:0]        bits;
      logic [5:0]         adv;
      logic [15:0]        total;
      logic               last;
   } column_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic [2:0]            req_tuser = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic [1:0]            rsp_tuser;
   logic                  rsp_tlast;
   logic                  csr_we = 1'b0;
   logic [1:0]            csr_index = '0;
   logic [7:0]            csr_wdata = '0;

   bitmap_glyph_column_renderer u_top (.*);

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Behavioural copy of the font memory, the glyph table and the line state.
   logic [7:0]  font_bytes [BITMAP_BYTES];
   bit          byte_known [BITMAP_BYTES];
   logic [15:0] entry_off  [GLYPH_ENTRIES];
   logic [5:0]  entry_wid  [GLYPH_ENTRIES];
   bit          entry_known[GLYPH_ENTRIES];
   int cursor_x = 0, line_top = 0, right_lim = 32767, bottom_lim = 32767;
   int width_total = 0;
   int cfg_first = 32, cfg_height = 16, cfg_fixed = 8;
   bit cfg_prop = 1'b0;

   column_type pending_cols[$];
   int      fails = 0;
   int      items_sent = 0;
   int      hold_left = 0;
   int      stall_count = 0;
   bit      calm = 1'b0;

   function automatic int min_int(input int a, input int b);
      return (a < b) ? a : b;
   endfunction

   // A code is drawable when it lies within the font and, in proportional
   // mode, within the glyph table.
   function automatic bit glyph_usable(input int ch);
      if (ch > 128 || ch < cfg_first) return 1'b0;
      if (cfg_prop && (ch - cfg_first) >= GLYPH_ENTRIES) return 1'b0;
      return 1'b1;
   endfunction

   function automatic void glyph_geometry(input int idx, output int w, output int pos,
                                          output int rows);
      rows = (min_int(cfg_height, MAX_HEIGHT) + 7) / 8;
      if (cfg_prop) begin
         w   = min_int(int'(entry_wid[idx]), COLUMN_LIMIT);
         pos = int'(entry_off[idx]);
      end else begin
         w   = min_int(cfg_fixed, COLUMN_LIMIT);
         pos = idx * w * rows;
      end
   endfunction

   // True when the transaction reads no memory location that was never loaded.
   function automatic bit reads_known(input glyph_req_type r);
      int w, pos, rows, idx;
      if (!(r.op == OP_DRAW || (r.op == OP_MEASURE && cfg_prop))) return 1'b1;
      if (!glyph_usable(int'(r.ch))) return 1'b1;
      idx = int'(r.ch) - cfg_first;
      if (cfg_prop && !entry_known[idx]) return 1'b0;
      if (r.op == OP_MEASURE) return 1'b1;
      glyph_geometry(idx, w, pos, rows);
      for (int i = 0; i < w; i++) begin
         if (cursor_x + i <= right_lim && cursor_x + i <= 32767) begin
            for (int c = 0; c < rows; c++) begin
               if (!byte_known[(pos + i + c * w) % BITMAP_BYTES]) return 1'b0;
            end
         end
      end
      return 1'b1;
   endfunction

   // Single response that is not a column: position is taken after the step.
   function automatic column_type status_word(input logic [1:0] kind, input int adv);
      column_type e;
      e.kind  = kind;
      e.x     = 16'(cursor_x);
      e.top   = 16'(line_top);
      e.bits  = '0;
      e.adv   = 6'(adv);
      e.total = 16'(width_total);
      e.last  = 1'b1;
      return e;
   endfunction

   // Works out the responses of one transaction and updates the state copy.
   task automatic render_columns(input glyph_req_type r, ref column_type res[$]);
      int      w, pos, rows, idx, x, k;
      column_type e;
      logic [7:0] b;
      res.delete();
      idx = int'(r.ch) - cfg_first;
      case (r.op)
         OP_LOAD_BYTE: begin
            font_bytes[r.addr % BITMAP_BYTES] = r.bval;
            byte_known[r.addr % BITMAP_BYTES] = 1'b1;
            res.push_back(status_word(KIND_ACK, 0));
         end
         OP_LOAD_ENTRY: begin
            entry_off[r.ch]   = r.eoff;
            entry_wid[r.ch]   = 6'(min_int(int'(r.ewid), COLUMN_LIMIT));
            entry_known[r.ch] = 1'b1;
            res.push_back(status_word(KIND_ACK, 0));
         end
         OP_START_LINE: begin
            cursor_x    = int'(r.sx);
            line_top    = int'(r.sy);
            right_lim   = int'(r.cr);
            bottom_lim  = int'(r.cb);
            width_total = 0;
            res.push_back(status_word(KIND_ACK, 0));
         end
         OP_DRAW: begin
            w = 0;
            if (glyph_usable(int'(r.ch))) glyph_geometry(idx, w, pos, rows);
            if (w == 0) begin
               res.push_back(status_word(KIND_NOTHING, 0));
            end else begin
               for (int i = 0; i < w; i++) begin
                  x = cursor_x + i;
                  e = status_word(KIND_COLUMN, w);
                  e.x    = 16'((x > 32767) ? 32767 : x);
                  e.last = (i == w - 1);
                  if (x <= right_lim && x <= 32767) begin
                     for (int c = 0; c < rows; c++) begin
                        b = font_bytes[(pos + i + c * w) % BITMAP_BYTES];
                        for (int j = 0; j < 8; j++) begin
                           k = c * 8 + j;
                           if (k < 32 && line_top + k <= bottom_lim && b[j]) e.bits[k] = 1'b1;
                        end
                     end
                  end
                  res.push_back(e);
               end
               cursor_x = min_int(cursor_x + w, 32767);
            end
         end
         OP_MEASURE: begin
            // Fixed mode counts every code, even those it would not draw.
            if (!cfg_prop || glyph_usable(int'(r.ch))) begin
               w = cfg_prop ? min_int(int'(entry_wid[idx]), COLUMN_LIMIT)
                            : min_int(cfg_fixed, COLUMN_LIMIT);
               width_total = min_int(width_total + w, 65535);
               res.push_back(status_word(KIND_MEASURE, w));
            end else begin
               res.push_back(status_word(KIND_NOTHING, 0));
            end
         end
         default: res.push_back(status_word(KIND_NOTHING, 0));
      endcase
   endtask

   function automatic glyph_req_type char_req(input logic [2:0] op, input logic [7:0] ch);
      glyph_req_type r = '0;
      r.op = op;
      r.ch = ch;
      return r;
   endfunction

   function automatic glyph_req_type byte_req(input int addr, input logic [7:0] val);
      glyph_req_type r = char_req(OP_LOAD_BYTE, 8'h00);
      r.addr = 16'(addr);
      r.bval = val;
      return r;
   endfunction

   function automatic glyph_req_type entry_req(input int idx, input int off, input int w);
      glyph_req_type r = char_req(OP_LOAD_ENTRY, 8'(idx));
      r.eoff = 16'(off);
      r.ewid = 6'(w);
      return r;
   endfunction

   function automatic glyph_req_type line_req(input int x, input int y, input int cr,
                                              input int cb);
      glyph_req_type r = char_req(OP_START_LINE, 8'h00);
      r.sx = 16'(x);
      r.sy = 16'(y);
      r.cr = 16'(cr);
      r.cb = 16'(cb);
      return r;
   endfunction

   function automatic column_type typed_word(input logic [1:0] kind, input int x,
                                             input int top, input int adv, input int total);
      column_type e;
      e.kind  = kind;
      e.x     = 16'(x);
      e.top   = 16'(top);
      e.bits  = '0;
      e.adv   = 6'(adv);
      e.total = 16'(total);
      e.last  = 1'b1;
      return e;
   endfunction

   // Offers one request transaction, with an occasional gap before it, and
   // queues its expected responses once it has been accepted. Where a typed
   // response is given it replaces the predicted one.
   task automatic send_glyph_op(input glyph_req_type r, input bit typed = 1'b0,
                                input column_type typed_col = '0);
      column_type res[$];
      if (!reads_known(r)) r.op = OP_UNUSED + 3'($urandom_range(0, 2));
      @(negedge clock);
      if (!calm && $urandom_range(0, 99) < 13) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= r.op;
      req_tdata  <= {2'b00, r.cb, r.cr, r.sy, r.sx, r.ewid, r.eoff, r.bval, r.addr, r.ch};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      render_columns(r, res);
      if (typed) pending_cols.push_back(typed_col);
      else foreach (res[i]) pending_cols.push_back(res[i]);
      items_sent++;
   endtask

   // Lowers the request valid and waits until every response has arrived.
   task automatic drain_responses();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (pending_cols.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_font(input int first, input int height, input int fixed_w,
                           input bit prop);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= CSR_FIRST_CODE;
      csr_wdata <= 8'(first);
      @(negedge clock);
      csr_index <= CSR_GLYPH_HEIGHT;
      csr_wdata <= 8'(height);
      @(negedge clock);
      csr_index <= CSR_FIXED_WIDTH;
      csr_wdata <= 8'(fixed_w);
      @(negedge clock);
      csr_index <= CSR_PROPORTIONAL;
      csr_wdata <= 8'(prop);
      @(negedge clock);
      csr_we    <= 1'b0;
      // The copies keep the raw values; saturation is applied when used.
      cfg_first  = first;
      cfg_height = height;
      cfg_fixed  = fixed_w;
      cfg_prop   = prop;
   endtask

   task automatic random_line();
      int x, y;
      if ($urandom_range(0, 3) == 0) begin
         send_glyph_op(line_req($urandom, $urandom, $urandom, $urandom));
      end else begin
         x = $urandom_range(0, 80) - 20;
         y = $urandom_range(0, 40) - 10;
         send_glyph_op(line_req(x, y, x + $urandom_range(0, 40) - 5,
                                y + $urandom_range(0, 40) - 4));
      end
   endtask

   // A well-formed burst: make a glyph loadable, then draw and measure it.
   task automatic glyph_sequence();
      int ch, idx, w, pos, rows, last_code;
      last_code = min_int(128, cfg_first + 15);
      ch = (cfg_first <= 128) ? $urandom_range(cfg_first, last_code) : $urandom_range(0, 255);
      if (glyph_usable(ch)) begin
         idx = ch - cfg_first;
         if (cfg_prop) begin
            w = ($urandom_range(0, 99) < 85) ? $urandom_range(0, 6) : $urandom_range(0, 63);
            send_glyph_op(entry_req(idx, $urandom, w));
         end
         glyph_geometry(idx, w, pos, rows);
         for (int n = 0; n < w * rows; n++) begin
            if (!byte_known[(pos + n) % BITMAP_BYTES] || $urandom_range(0, 7) == 0)
               send_glyph_op(byte_req((pos + n) % BITMAP_BYTES +
                                      BITMAP_BYTES * $urandom_range(0, 3), 8'($urandom)));
         end
      end
      if ($urandom_range(0, 9) < 3) random_line();
      repeat ($urandom_range(1, 3)) send_glyph_op(char_req(OP_DRAW, 8'(ch)));
      send_glyph_op(char_req(OP_MEASURE, 8'(ch)));
   endtask

   task automatic random_phase(input int count);
      glyph_req_type r;
      int goal, pick;
      goal = items_sent + count;
      while (items_sent < goal) begin
         pick = $urandom_range(0, 99);
         if (pick < 55) begin
            glyph_sequence();
         end else if (pick < 70) begin
            random_line();
         end else if (pick < 85) begin
            send_glyph_op(char_req(OP_MEASURE, 8'($urandom)));
         end else begin
            // Noise: any operation with every field random.
            r = REQ_BITS'({$urandom, $urandom, $urandom, $urandom});
            send_glyph_op(r);
         end
      end
   endtask

   // Response side: random back-pressure, plus long hold-offs on request.
   always @(negedge clock) begin
      if (hold_left > 0) begin
         hold_left  <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= calm || ($urandom_range(0, 99) >= 13);
      end
   end

   always @(posedge clock) begin
      column_type got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = {rsp_tuser, rsp_tdata[15:0], rsp_tdata[31:16], rsp_tdata[63:32],
                rsp_tdata[69:64], rsp_tdata[85:70], rsp_tlast};
         if (pending_cols.size() == 0) begin
            fails++;
            if (fails <= 10) $display("Unexpected response transaction: %p", got);
         end else begin
            want = pending_cols.pop_front();
            if (got.kind !== want.kind || got.x !== want.x || got.top !== want.top ||
                got.bits !== want.bits || got.adv !== want.adv ||
                got.total !== want.total || got.last !== want.last) begin
               fails++;
               if (fails <= 10) begin
                  $display("Response differs at %0t", $realtime);
                  $display("  expected kind %0d x %0d top %0d bits %h adv %0d total %0d last %0b",
                           want.kind, want.x, want.top, want.bits, want.adv, want.total,
                           want.last);
                  $display("  actual   kind %0d x %0d top %0d bits %h adv %0d total %0d last %0b",
                           got.kind, got.x, got.top, got.bits, got.adv, got.total, got.last);
               end
            end
         end
      end
   end

   // Watchdog: gives up when no transaction has moved for too long.
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         stall_count <= 0;
      end else if (stall_count >= STALL_LIMIT) begin
         $display("bitmap_glyph_column_renderer: mismatch");
         $finish;
      end else begin
         stall_count <= stall_count + 1;
      end
   end

   // Directed stimulus table; a set flag means the typed response is used.
   glyph_req_type dir_req[$];
   bit            dir_typed[$];
   column_type    dir_col[$];

   task automatic add_row(input glyph_req_type r, input bit typed = 1'b0,
                          input column_type e = '0);
      dir_req.push_back(r);
      dir_typed.push_back(typed);
      dir_col.push_back(e);
   endtask

   initial begin
      glyph_req_type r;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Reset font: first code 32, 16 pixels high, 8 columns, fixed mode.
      add_row(char_req(OP_MEASURE, 8'h41), 1, typed_word(KIND_MEASURE, 0, 0, 8, 8));
      // A fixed-width measure counts codes that could never be drawn.
      add_row(char_req(OP_MEASURE, 8'hFF), 1, typed_word(KIND_MEASURE, 0, 0, 8, 16));
      add_row(char_req(OP_UNUSED + 3'd2, 8'h00), 1, typed_word(KIND_NOTHING, 0, 0, 0, 16));
      add_row(line_req(-32768, 32767, 32767, 32767), 1,
              typed_word(KIND_ACK, -32768, 32767, 0, 0));
      // Codes above 0x80 and below the first code are skipped.
      add_row(char_req(OP_DRAW, 8'h81), 1, typed_word(KIND_NOTHING, -32768, 32767, 0, 0));
      add_row(char_req(OP_DRAW, 8'h1F), 1, typed_word(KIND_NOTHING, -32768, 32767, 0, 0));
      // An oversized entry width is stored saturated; entry 0 gets zero width.
      add_row(entry_req(255, 16'hFFFF, 63), 1, typed_word(KIND_ACK, -32768, 32767, 0, 0));
      add_row(entry_req(0, 0, 0), 1, typed_word(KIND_ACK, -32768, 32767, 0, 0));
      // The address wraps round the bitmap memory onto byte 0.
      add_row(byte_req(16'hC000, 8'hFF), 1, typed_word(KIND_ACK, -32768, 32767, 0, 0));
      add_row(byte_req(16'h0008, 8'hA5), 1, typed_word(KIND_ACK, -32768, 32767, 0, 0));
      add_row(line_req(32765, -4, 32765, 5), 1, typed_word(KIND_ACK, 32765, -4, 0, 0));
      // Right clip, bottom clip and saturation of column x and the cursor.
      add_row(char_req(OP_DRAW, 8'h20));
      add_row(char_req(OP_DRAW, 8'h80));
      add_row(char_req(OP_MEASURE, 8'h20), 1, typed_word(KIND_MEASURE, 32767, -4, 8, 8));
      add_row(char_req(OP_UNUSED, 8'hFF), 1, typed_word(KIND_NOTHING, 32767, -4, 0, 8));
      add_row(line_req(0, 0, -32768, -32768), 1, typed_word(KIND_ACK, 0, 0, 0, 0));
      add_row(char_req(OP_DRAW, 8'h40));
      add_row(char_req(OP_UNUSED + 3'd1, 8'h00), 1, typed_word(KIND_NOTHING, 8, 0, 0, 0));
      foreach (dir_req[i]) send_glyph_op(dir_req[i], dir_typed[i], dir_col[i]);
      drain_responses();

      // Proportional, first code 0, one pixel high; entry 0 has zero width.
      set_font(0, 1, 1, 1'b1);
      send_glyph_op(char_req(OP_DRAW, 8'h00));
      random_phase(30);
      drain_responses();

      // Widest glyphs; the receiver holds off while the sender keeps
      // offering, then a run of measures adds up the total.
      set_font(32, 8, 32, 1'b0);
      hold_left = 400;
      random_phase(30);
      send_glyph_op(line_req(0, 0, 32767, 32767));
      repeat (15) send_glyph_op(char_req(OP_MEASURE, 8'($urandom)));
      drain_responses();

      // First code 255: nothing is drawable, but fixed measures still count
      // with the oversized width saturated.
      set_font(255, 8, 63, 1'b0);
      random_phase(20);
      drain_responses();

      // Oversized height saturates; no idling on either side.
      calm = 1'b1;
      set_font(100, 63, 2, 1'b0);
      random_phase(30);
      drain_responses();
      calm = 1'b0;

      set_font(20, 12, 5, 1'b1);
      random_phase(30);
      drain_responses();

      set_font(32, 16, 8, 1'b0);
      random_phase(30);
      drain_responses();

      if (fails == 0) begin
         $display("bitmap_glyph_column_renderer: match");
      end else begin
         $display("bitmap_glyph_column_renderer: mismatch");
      end
      $finish;
   end

endmodule
